@@ rtl/tcf_pkg.sv @@
package tcf_pkg;

    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int TILE_DEF  = 8;
    localparam int FRAC_DEF  = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIV_RD,
        S_PIV_CHK,
        S_SQRT,
        S_COL_RD,
        S_COL_START,
        S_COL_WAIT,
        S_UPD_A,
        S_UPD_B,
        S_UPD_MUL,
        S_UPD_WR,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_ERR
    } state_t;

    // packed lower-triangle address of (r, c)
    function automatic logic [5:0] tri_addr(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
        logic [5:0] rr;
        rr = {3'b000, r};
        return ((rr * (rr + 6'd1)) >> 1) + {3'b000, c};
    endfunction

endpackage

@@ rtl/tcf_ram.sv @@
module tcf_ram #(
    parameter int DEPTH  = 36,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tcf_arith.sv @@
module tcf_arith #(
    parameter int FRAC_BITS = tcf_pkg::FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start_sqrt,
    input  logic                              start_div,
    input  logic signed [tcf_pkg::DATA_W-1:0] operand,
    input  logic        [tcf_pkg::DATA_W-1:0] divisor,
    output logic                              done,
    output logic signed [tcf_pkg::DATA_W-1:0] result
);

    localparam int RW    = 32 + FRAC_BITS + (FRAC_BITS % 2);
    localparam int HW    = RW / 2;
    localparam int REM_W = 34;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg, busy_next;
    logic             sqrt_reg, sqrt_next;
    logic             done_reg, done_next;
    logic             sign_reg, sign_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]    sh_reg, sh_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [HW-1:0]    root_reg, root_next;
    logic [REM_W-1:0] rem_s, trial;
    logic [31:0]      mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        sign_reg <= sign_next;
        cnt_reg  <= cnt_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        sqrt_next = sqrt_reg;
        done_next = 1'b0;
        sign_next = sign_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        mag       = operand[31] ? 32'(-operand) : 32'(operand);
        rem_s     = '0;
        trial     = '0;
        if (start_sqrt || start_div)
        begin
            busy_next = 1'b1;
            sqrt_next = start_sqrt;
            sign_next = operand[31];
            cnt_next  = start_sqrt ? CNT_W'(HW) : CNT_W'(RW);
            sh_next   = RW'(mag) << FRAC_BITS;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                // one root digit per cycle
                rem_s = {rem_reg[REM_W-3:0], sh_reg[RW-1:RW-2]};
                trial = {(REM_W-2)'(root_reg), 2'b01};
                sh_next = {sh_reg[RW-3:0], 2'b00};
                if (rem_s >= trial)
                begin
                    rem_next  = rem_s - trial;
                    root_next = {root_reg[HW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_s;
                    root_next = {root_reg[HW-2:0], 1'b0};
                end
            end
            else
            begin
                // one quotient bit per cycle, shifted in behind the dividend
                rem_s = {rem_reg[REM_W-2:0], sh_reg[RW-1]};
                if (rem_s >= REM_W'(divisor))
                begin
                    rem_next = rem_s - REM_W'(divisor);
                    sh_next  = {sh_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_s;
                    sh_next  = {sh_reg[RW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (sqrt_reg)
        begin
            result = 32'(root_reg);
        end
        else if (sign_reg)
        begin
            result = (sh_reg > RW'(33'h080000000)) ? 32'sh80000000 : 32'(-sh_reg);
        end
        else
        begin
            result = (sh_reg > RW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(sh_reg);
        end
    end

    assign done = done_reg;

endmodule

@@ rtl/tile_cholesky_factor_top.sv @@
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// load      | start / busy           | row, col, value, last
// result    | result_valid (strobe)  | out_row, out_col, l_value, not_spd, last_out
// config    | cfg_we                 | cfg_wdata (tile_size)
//
// A beat with last starts the factorization; busy stays high until the final result
// beat. Per pivot a square root runs, per column entry a division, and per trailing
// update the factor memory is read twice in turn (one read port on the factor memory),
// then each entry is read and emitted in turn.
// Reset is asynchronous, active low; the tile memory is undefined until loaded.
// The receiver cannot stall: each result beat shows for one cycle.
module tile_cholesky_factor_top #(
    parameter int TILE      = tcf_pkg::TILE_DEF,
    parameter int FRAC_BITS = tcf_pkg::FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tcf_pkg::IDX_W-1:0]         row,
    input  logic [tcf_pkg::IDX_W-1:0]         col,
    input  logic signed [tcf_pkg::DATA_W-1:0] value,
    input  logic                              last,
    input  logic                              cfg_we,
    input  logic [tcf_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                              result_valid,
    output logic [tcf_pkg::IDX_W-1:0]         out_row,
    output logic [tcf_pkg::IDX_W-1:0]         out_col,
    output logic signed [tcf_pkg::DATA_W-1:0] l_value,
    output logic                              not_spd,
    output logic                              last_out
);

    localparam int DEPTH  = TILE * (TILE + 1) / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW     = tcf_pkg::IDX_W;
    localparam int TILE_RESET = 8;

    tcf_pkg::state_t state_reg, state_next;

    logic [tcf_pkg::CFG_W-1:0] size_reg;
    logic [IW-1:0] k_reg, k_next, i_reg, i_next, j_reg, j_next, nm1_reg, nm1_next;
    logic signed [31:0] d_reg, d_next, lik_reg, lik_next, a_reg, a_next;
    logic signed [63:0] prod_reg, prod_next;

    logic              s_we, l_we;
    logic [5:0]        s_wa6, s_ra6, l_wa6, l_ra6;
    logic [31:0]       s_wdata, l_wdata, s_rdata, l_rdata;
    logic              start_sqrt, start_div, ar_done;
    logic signed [31:0] ar_result;
    logic signed [64:0] nv;
    logic [IW-1:0]     k_inc, i_inc, j_inc;

    tcf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(tcf_pkg::DATA_W)) u_store (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_wa6[ADDR_W-1:0]),
        .wdata (s_wdata),
        .raddr (s_ra6[ADDR_W-1:0]),
        .rdata (s_rdata)
    );

    tcf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(tcf_pkg::DATA_W)) u_factor (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_wa6[ADDR_W-1:0]),
        .wdata (l_wdata),
        .raddr (l_ra6[ADDR_W-1:0]),
        .rdata (l_rdata)
    );

    tcf_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_sqrt (start_sqrt),
        .start_div  (start_div),
        .operand    (s_rdata),
        .divisor    (d_reg),
        .done       (ar_done),
        .result     (ar_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcf_pkg::S_IDLE;
            size_reg  <= tcf_pkg::CFG_W'(TILE_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        nm1_reg  <= nm1_next;
        d_reg    <= d_next;
        lik_reg  <= lik_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign k_inc = k_reg + IW'(1);
    assign i_inc = i_reg + IW'(1);
    assign j_inc = j_reg + IW'(1);
    assign nv    = 65'(a_reg) - 65'(prod_reg >>> FRAC_BITS);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        nm1_next   = nm1_reg;
        d_next     = d_reg;
        lik_next   = lik_reg;
        a_next     = a_reg;
        prod_next  = prod_reg;
        s_we       = 1'b0;
        s_wa6      = tcf_pkg::tri_addr(i_reg, j_reg);
        s_wdata    = value;
        s_ra6      = tcf_pkg::tri_addr(k_reg, k_reg);
        l_we       = 1'b0;
        l_wa6      = tcf_pkg::tri_addr(k_reg, k_reg);
        l_wdata    = ar_result;
        l_ra6      = tcf_pkg::tri_addr(i_reg, k_reg);
        start_sqrt = 1'b0;
        start_div  = 1'b0;
        unique case (state_reg)
            tcf_pkg::S_IDLE:
            begin
                if (start)
                begin
                    s_wa6 = tcf_pkg::tri_addr(row, col);
                    s_we  = (col <= row) && (int'(row) < TILE);
                    if (last)
                    begin
                        k_next = '0;
                        if (size_reg == '0)
                        begin
                            nm1_next = '0;
                        end
                        else if (int'(size_reg) > TILE)
                        begin
                            nm1_next = IW'(TILE - 1);
                        end
                        else
                        begin
                            nm1_next = IW'(size_reg - tcf_pkg::CFG_W'(1));
                        end
                        state_next = tcf_pkg::S_PIV_RD;
                    end
                end
            end
            tcf_pkg::S_PIV_RD:
            begin
                state_next = tcf_pkg::S_PIV_CHK;
            end
            tcf_pkg::S_PIV_CHK:
            begin
                if (s_rdata[31] || s_rdata == '0)
                begin
                    state_next = tcf_pkg::S_ERR;
                end
                else
                begin
                    start_sqrt = 1'b1;
                    state_next = tcf_pkg::S_SQRT;
                end
            end
            tcf_pkg::S_SQRT:
            begin
                if (ar_done)
                begin
                    l_we   = 1'b1;
                    d_next = ar_result;
                    j_next = k_inc;
                    if (k_reg == nm1_reg)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = tcf_pkg::S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = tcf_pkg::S_COL_RD;
                    end
                end
            end
            tcf_pkg::S_COL_RD:
            begin
                s_ra6      = tcf_pkg::tri_addr(j_reg, k_reg);
                state_next = tcf_pkg::S_COL_START;
            end
            tcf_pkg::S_COL_START:
            begin
                start_div  = 1'b1;
                state_next = tcf_pkg::S_COL_WAIT;
            end
            tcf_pkg::S_COL_WAIT:
            begin
                if (ar_done)
                begin
                    l_we  = 1'b1;
                    l_wa6 = tcf_pkg::tri_addr(j_reg, k_reg);
                    if (j_reg == nm1_reg)
                    begin
                        j_next     = k_inc;
                        i_next     = k_inc;
                        state_next = tcf_pkg::S_UPD_A;
                    end
                    else
                    begin
                        j_next     = j_inc;
                        state_next = tcf_pkg::S_COL_RD;
                    end
                end
            end
            tcf_pkg::S_UPD_A:
            begin
                l_ra6      = tcf_pkg::tri_addr(i_reg, k_reg);
                s_ra6      = tcf_pkg::tri_addr(i_reg, j_reg);
                state_next = tcf_pkg::S_UPD_B;
            end
            tcf_pkg::S_UPD_B:
            begin
                lik_next   = l_rdata;
                a_next     = s_rdata;
                l_ra6      = tcf_pkg::tri_addr(j_reg, k_reg);
                state_next = tcf_pkg::S_UPD_MUL;
            end
            tcf_pkg::S_UPD_MUL:
            begin
                prod_next  = 64'(lik_reg) * 64'(signed'(l_rdata));
                state_next = tcf_pkg::S_UPD_WR;
            end
            tcf_pkg::S_UPD_WR:
            begin
                s_we = 1'b1;
                if (nv > 65'sh07fffffff)
                begin
                    s_wdata = 32'h7fffffff;
                end
                else if (nv < -65'sh080000000)
                begin
                    s_wdata = 32'h80000000;
                end
                else
                begin
                    s_wdata = nv[31:0];
                end
                if (i_reg != nm1_reg)
                begin
                    i_next     = i_inc;
                    state_next = tcf_pkg::S_UPD_A;
                end
                else if (j_reg != nm1_reg)
                begin
                    j_next     = j_inc;
                    i_next     = j_inc;
                    state_next = tcf_pkg::S_UPD_A;
                end
                else
                begin
                    // the trailing update only runs while k is below the last pivot
                    k_next     = k_inc;
                    state_next = tcf_pkg::S_PIV_RD;
                end
            end
            tcf_pkg::S_EMIT_RD:
            begin
                l_ra6      = tcf_pkg::tri_addr(i_reg, j_reg);
                state_next = tcf_pkg::S_EMIT_OUT;
            end
            tcf_pkg::S_EMIT_OUT:
            begin
                if (j_reg != i_reg)
                begin
                    j_next     = j_inc;
                    state_next = tcf_pkg::S_EMIT_RD;
                end
                else if (i_reg != nm1_reg)
                begin
                    i_next     = i_inc;
                    j_next     = '0;
                    state_next = tcf_pkg::S_EMIT_RD;
                end
                else
                begin
                    state_next = tcf_pkg::S_IDLE;
                end
            end
            tcf_pkg::S_ERR:
            begin
                state_next = tcf_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tcf_pkg::S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != tcf_pkg::S_IDLE);
    assign result_valid = (state_reg == tcf_pkg::S_EMIT_OUT) || (state_reg == tcf_pkg::S_ERR);
    assign not_spd      = (state_reg == tcf_pkg::S_ERR);
    assign out_row      = not_spd ? k_reg : i_reg;
    assign out_col      = not_spd ? k_reg : j_reg;
    assign l_value      = (state_reg == tcf_pkg::S_EMIT_OUT) ? signed'(l_rdata) : '0;
    assign last_out     = not_spd || ((state_reg == tcf_pkg::S_EMIT_OUT)
                          && (i_reg == nm1_reg) && (j_reg == i_reg));

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat outside a factorization");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        not_spd |-> (last_out && l_value == '0))
        else $error("error beat must be final and carry zero");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> busy)
        else $error("factorization did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_out) |=> !busy)
        else $error("busy after final result beat");

endmodule
